### rtl/assert_macros.svh
// Assertion macros for the RTL of the first-free allocator.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BFFA_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define BFFA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### rtl/bffa_pkg.sv
// Package for the bitmap first-free allocator: item types, status codes and widths.
// Depends on nothing.
`default_nettype none

package bffa_pkg;

   localparam int WORD_BITS   = 32;
   localparam int BIT_W       = 5;
   localparam int DEF_ENTRIES = 128;

   localparam int IDX_W  = 7;
   localparam int FREE_W = 8;
   localparam int STAT_W = 2;

   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   localparam logic [STAT_W-1:0] ST_GRANTED     = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL        = 2'd1;
   localparam logic [STAT_W-1:0] ST_RELEASED    = 2'd2;
   localparam logic [STAT_W-1:0] ST_BAD_RELEASE = 2'd3;

   typedef struct packed {
      logic             command;
      logic [IDX_W-1:0] release_index;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [IDX_W-1:0]  granted_index;
      logic [FREE_W-1:0] free_left;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/bitmap_first_free_allocator_core.sv
// Top level of the bitmap first-free allocator: sequencer, bitmap memory and free count.
// Depends on bffa_pkg and assert_macros.svh.
//
// An item is taken when start is high and busy is low; its single result appears on rsp_data
// for exactly one cycle with rsp_valid high and cannot be held off. An allocate scans the
// bitmap one 32-bit word at a time through a single registered memory read port, passing
// through states READ and CHECK for each word read, up to and including the one holding
// the lowest free entry, at most ceil(ENTRIES/32) words. A release reads one word in the
// same states, rewriting it if the index was allocated and answering ST_BAD_RELEASE if not.
// An allocate when nothing is free, or a release of an index not below ENTRIES, answers in
// the next cycle. busy falls in the cycle the result is shown, so a new item can be taken
// then. Reset clears a valid flag per word at once; no clearing pass follows reset.
`default_nettype none

`include "assert_macros.svh"

module bitmap_first_free_allocator_core #(
   parameter int ENTRIES = bffa_pkg::DEF_ENTRIES
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output      logic             busy,
   input  wire bffa_pkg::req_type req_data,
   output      logic             rsp_valid,
   output      bffa_pkg::rsp_type rsp_data
);

   import bffa_pkg::*;

   localparam int WORDS = (ENTRIES + WORD_BITS - 1) / WORD_BITS;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CW    = $clog2(ENTRIES + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_CHECK = 2'd2;

   logic [WORD_BITS-1:0] map_mem [WORDS];

   logic [1:0]           state_ff, state_in;
   logic [AW-1:0]        ptr_ff, ptr_in;
   logic                 cmd_ff, cmd_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [WORDS-1:0]     valid_ff, valid_in;
   logic [WORD_BITS-1:0] rdata_ff;
   logic                 rd_valid_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 accept;
   logic                 wr_en;
   logic [WORD_BITS-1:0] wr_data;
   logic [WORD_BITS-1:0] word;
   logic [WORD_BITS-1:0] pad_mask;
   logic [WORD_BITS-1:0] eff;
   logic                 zero_found;
   logic [BIT_W-1:0]     zero_pos;
   logic [AW-1:0]        rel_word;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rel_word  = AW'(32'(req_data.release_index) >> BIT_W);

   assign word = rd_valid_ff ? rdata_ff : '0;
   assign eff  = word | pad_mask;

   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         pad_mask[b] = ((int'(ptr_ff) * WORD_BITS + b) >= ENTRIES);
      end
   end

   always_comb begin
      zero_found = 1'b0;
      zero_pos   = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (!eff[b]) begin
            zero_found = 1'b1;
            zero_pos   = BIT_W'(b);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      cmd_in       = cmd_ff;
      bit_in       = bit_ff;
      count_in     = count_ff;
      valid_in     = valid_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_data      = word;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in = req_data.command;
               bit_in = req_data.release_index[BIT_W-1:0];
               rsp_in.granted_index = '0;
               rsp_in.free_left     = FREE_W'(count_ff);
               if (req_data.command == CMD_ALLOC) begin
                  ptr_in = '0;
                  if (count_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = ST_FULL;
                  end else begin
                     state_in = S_READ;
                  end
               end else begin
                  ptr_in = rel_word;
                  if (32'(req_data.release_index) >= ENTRIES) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = ST_BAD_RELEASE;
                  end else begin
                     state_in = S_READ;
                  end
               end
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            rsp_in.granted_index = '0;
            rsp_in.free_left     = FREE_W'(count_ff);
            if (cmd_ff == CMD_ALLOC) begin
               if (zero_found) begin
                  wr_en                = 1'b1;
                  wr_data              = word | (WORD_BITS'(1) << zero_pos);
                  valid_in[ptr_ff]     = 1'b1;
                  count_in             = count_ff - 1'b1;
                  rsp_valid_in         = 1'b1;
                  rsp_in.status        = ST_GRANTED;
                  rsp_in.granted_index = IDX_W'({ptr_ff, zero_pos});
                  rsp_in.free_left     = FREE_W'(count_ff - 1'b1);
                  state_in             = S_IDLE;
               end else if (ptr_ff == AW'(WORDS - 1)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = ST_FULL;
                  state_in      = S_IDLE;
               end else begin
                  ptr_in   = ptr_ff + 1'b1;
                  state_in = S_READ;
               end
            end else begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               if (word[bit_ff]) begin
                  wr_en            = 1'b1;
                  wr_data          = word & ~(WORD_BITS'(1) << bit_ff);
                  valid_in[ptr_ff] = 1'b1;
                  count_in         = count_ff + 1'b1;
                  rsp_in.status    = ST_RELEASED;
                  rsp_in.free_left = FREE_W'(count_ff + 1'b1);
               end else begin
                  rsp_in.status = ST_BAD_RELEASE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= CW'(ENTRIES);
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      cmd_ff <= cmd_in;
      bit_ff <= bit_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_READ) begin
         rdata_ff    <= map_mem[ptr_ff];
         rd_valid_ff <= valid_ff[ptr_ff];
      end
   end

   `BFFA_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(ENTRIES))
   `BFFA_ASSERT_NEXT(a_accept_progress, clock, reset, accept, busy || rsp_valid)
   `BFFA_ASSERT_NEXT(a_grant_from_scan, clock, reset,
      state_ff == S_CHECK && cmd_ff == CMD_ALLOC && zero_found,
      rsp_valid && rsp_data.status == ST_GRANTED)

endmodule

`default_nettype wire

### test/tb_bitmap_first_free_allocator_core.sv
// Self-checking testbench for bitmap_first_free_allocator_core: a directed table, then phases
// of random allocates and releases, checked against typed rows or an allocator model.
// Depends on bffa_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb_bitmap_first_free_allocator_core;
   import bffa_pkg::*;

   localparam int ENTRY_COUNT   = DEF_ENTRIES;
   localparam int ITEM_TARGET   = 1450;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = 16;
   localparam int REPORT_LIMIT  = 10;
   localparam int PHASE_FILL    = 0;
   localparam int PHASE_DRAIN   = 1;
   localparam int PHASE_MIXED   = 2;

   typedef struct packed {
      bit      typed;
      req_type item;
      rsp_type outcome;
   } plan_row_type;

   localparam int PLAN_ROWS = 16;
   localparam plan_row_type ALLOCATOR_PLAN [PLAN_ROWS] = '{
      '{1'b1, '{CMD_ALLOC,   7'd0},   '{ST_GRANTED,     7'd0, 8'd127}},
      '{1'b1, '{CMD_ALLOC,   7'd127}, '{ST_GRANTED,     7'd1, 8'd126}},
      '{1'b1, '{CMD_ALLOC,   7'd85},  '{ST_GRANTED,     7'd2, 8'd125}},
      '{1'b1, '{CMD_RELEASE, 7'd127}, '{ST_BAD_RELEASE, 7'd0, 8'd125}},
      '{1'b1, '{CMD_RELEASE, 7'd1},   '{ST_RELEASED,    7'd0, 8'd126}},
      '{1'b1, '{CMD_RELEASE, 7'd1},   '{ST_BAD_RELEASE, 7'd0, 8'd126}},
      '{1'b1, '{CMD_ALLOC,   7'd42},  '{ST_GRANTED,     7'd1, 8'd125}},
      '{1'b1, '{CMD_RELEASE, 7'd0},   '{ST_RELEASED,    7'd0, 8'd126}},
      '{1'b1, '{CMD_RELEASE, 7'd2},   '{ST_RELEASED,    7'd0, 8'd127}},
      '{1'b1, '{CMD_RELEASE, 7'd1},   '{ST_RELEASED,    7'd0, 8'd128}},
      '{1'b1, '{CMD_RELEASE, 7'd0},   '{ST_BAD_RELEASE, 7'd0, 8'd128}},
      '{1'b1, '{CMD_RELEASE, 7'd64},  '{ST_BAD_RELEASE, 7'd0, 8'd128}},
      '{1'b0, '{CMD_ALLOC,   7'd0},   '{ST_GRANTED,     7'd0, 8'd0}},
      '{1'b0, '{CMD_ALLOC,   7'd127}, '{ST_GRANTED,     7'd0, 8'd0}},
      '{1'b0, '{CMD_RELEASE, 7'd0},   '{ST_GRANTED,     7'd0, 8'd0}},
      '{1'b0, '{CMD_ALLOC,   7'd0},   '{ST_GRANTED,     7'd0, 8'd0}}
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   bit          entry_used [ENTRY_COUNT];
   int          free_entries;
   rsp_type     expected_outcomes [$];
   int          mismatch_count = 0;
   int          items_sent = 0;
   int unsigned cycle_count = 0;

   bitmap_first_free_allocator_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic rsp_type allocator_outcome(input req_type item);
      rsp_type outcome;
      int      slot;
      int      k;
      outcome = '0;
      slot = -1;
      if (item.command == CMD_ALLOC) begin
         for (k = 0; k < ENTRY_COUNT; k++)
            if (!entry_used[k] && slot < 0)
               slot = k;
         if (slot < 0) begin
            outcome.status = ST_FULL;
         end else begin
            entry_used[slot] = 1'b1;
            free_entries--;
            outcome.status = ST_GRANTED;
            outcome.granted_index = IDX_W'(slot);
         end
      end else if (int'(item.release_index) >= ENTRY_COUNT
                   || !entry_used[item.release_index]) begin
         outcome.status = ST_BAD_RELEASE;
      end else begin
         entry_used[item.release_index] = 1'b0;
         free_entries++;
         outcome.status = ST_RELEASED;
      end
      outcome.free_left = FREE_W'(free_entries);
      return outcome;
   endfunction

   function automatic logic [IDX_W-1:0] pick_used_entry();
      int origin;
      int k;
      origin = $urandom_range(0, ENTRY_COUNT - 1);
      for (k = 0; k < ENTRY_COUNT; k++)
         if (entry_used[(origin + k) % ENTRY_COUNT])
            return IDX_W'((origin + k) % ENTRY_COUNT);
      return IDX_W'(origin);
   endfunction

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic issue_request(input req_type item, input bit typed, input rsp_type typed_outcome,
                                input int unsigned gap);
      rsp_type predicted;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      predicted = allocator_outcome(item);
      expected_outcomes.push_back(typed ? typed_outcome : predicted);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic note_mismatch(input string what, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("mismatch at cycle %0d: %s expected %0d, got %0d", cycle_count, what, want, got);
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_outcomes.size() == 0) begin
            note_mismatch("result with nothing outstanding, status", -1,
                          int'(rsp_data.status));
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_data.status !== want.status)
               note_mismatch("status", int'(want.status), int'(rsp_data.status));
            if (rsp_data.granted_index !== want.granted_index)
               note_mismatch("granted_index", int'(want.granted_index),
                             int'(rsp_data.granted_index));
            if (rsp_data.free_left !== want.free_left)
               note_mismatch("free_left", int'(want.free_left), int'(rsp_data.free_left));
         end
      end
   end

   initial begin : stimulus
      req_type     item;
      int          phase_kind;
      int          phase_length;
      int          alloc_percent;
      bit          steady;
      int unsigned gap;
      int          i;
      foreach (entry_used[k])
         entry_used[k] = 1'b0;
      free_entries = ENTRY_COUNT;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (i = 0; i < PLAN_ROWS; i++)
         issue_request(ALLOCATOR_PLAN[i].item, ALLOCATOR_PLAN[i].typed,
                       ALLOCATOR_PLAN[i].outcome, $urandom_range(0, 19));

      while (items_sent < ITEM_TARGET + PLAN_ROWS) begin
         phase_kind = $urandom_range(PHASE_FILL, PHASE_MIXED);
         phase_length = $urandom_range(60, 240);
         steady = ($urandom_range(0, 3) == 0);
         case (phase_kind)
            PHASE_FILL:  alloc_percent = 90;
            PHASE_DRAIN: alloc_percent = 10;
            default:     alloc_percent = 50;
         endcase
         for (i = 0; i < phase_length && items_sent < ITEM_TARGET + PLAN_ROWS; i++) begin
            item.release_index = IDX_W'($urandom);
            if ($urandom_range(1, 100) <= alloc_percent) begin
               item.command = CMD_ALLOC;
            end else begin
               item.command = CMD_RELEASE;
               if ($urandom_range(1, 100) <= 85)
                  item.release_index = pick_used_entry();
            end
            gap = steady ? 0 : $urandom_range(0, 19);
            issue_request(item, 1'b0, '0, gap);
         end
      end
      start <= 1'b0;

      while (expected_outcomes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/bffa_pkg.sv
rtl/bitmap_first_free_allocator_core.sv
test/tb_bitmap_first_free_allocator_core.sv
